>>> hdl/window_layer_ownership_map_defines.svh
// assertion macros for the window layer ownership map
`ifndef WINDOW_LAYER_OWNERSHIP_MAP_DEFINES_SVH
`define WINDOW_LAYER_OWNERSHIP_MAP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, off while reset is asserted
`define WLOM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define WLOM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WLOM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WLOM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/wlom_pkg.sv
// shared types and constants for the window layer ownership map
`default_nettype none

package wlom_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PAINT = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLUMNS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS    = 1'b1;
  localparam logic [7:0] SCREEN_COLUMNS_RESET = 8'd80;
  localparam logic [6:0] SCREEN_ROWS_RESET    = 7'd24;

  // signed widths for rectangle clipping math; layer and port id widths
  localparam int COL_CALC_W = 12;
  localparam int ROW_CALC_W = 11;
  localparam int LAYER_W    = 16;
  localparam int PORT_ID_W  = 16;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_PAINT = 3'd2,
    ST_QREAD = 3'd3,
    ST_QOUT  = 3'd4
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // latch a new item
    logic paint_step;  // tag the walker cell for write-back and advance the walker
    logic rd_en;       // memory read at walker address
    logic clr_en;      // write one empty entry and advance sweep
    logic out_load;    // load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic paint_nonempty;  // clipped rectangle has at least one cell
    logic paint_last;      // walker sits on the last cell
    logic clr_last;        // sweep sits on the last entry
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/wlom_datapath.sv
// datapath: config registers, rectangle walker, ownership memory, result register
`default_nettype none

module wlom_datapath #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int ID_BITS     = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wlom_pkg::cmd_t                       cmd,
  output wlom_pkg::sts_t                       sts,
  input  wire  [15:0]                          in_window_id,
  input  wire  signed [8:0]                    in_left_column,
  input  wire  signed [7:0]                    in_top_row,
  input  wire  [7:0]                           in_rect_width,
  input  wire  [6:0]                           in_rect_height,
  input  wire  signed [15:0]                   in_layer,
  input  wire                                  cfg_we,
  input  wire  [wlom_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [wlom_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [15:0]                          out_owner_id,
  output logic signed [15:0]                   out_owner_layer,
  output logic                                 out_cell_valid
);
  import wlom_pkg::*;

  localparam int CB    = $clog2(MAX_COLUMNS);
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int AW    = CB + RB;
  localparam int DEPTH = MAX_ROWS * (2 ** CB);
  localparam int EW    = ID_BITS + LAYER_W;
  localparam logic signed [COL_CALC_W-1:0] MAX_COLS_S = COL_CALC_W'(MAX_COLUMNS);
  localparam logic signed [ROW_CALC_W-1:0] MAX_ROWS_S = ROW_CALC_W'(MAX_ROWS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // configuration registers
  logic [7:0] screen_cols_r;
  logic [6:0] screen_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_cols_r <= SCREEN_COLUMNS_RESET;
      screen_rows_r <= SCREEN_ROWS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SCREEN_COLUMNS) begin
        screen_cols_r <= cfg_wdata[7:0];
      end else if (cfg_index == REG_SCREEN_ROWS) begin
        screen_rows_r <= cfg_wdata[6:0];
      end
    end
  end

  // clip the rectangle against the usable area
  logic signed [COL_CALC_W-1:0] left_s, width_s, col_end_raw, acols_s, cols_ext;
  logic signed [COL_CALC_W-1:0] col_start, col_end, col_end_m1;
  logic signed [ROW_CALC_W-1:0] top_s, height_s, row_end_raw, arows_s, rows_ext;
  logic signed [ROW_CALC_W-1:0] row_start, row_end, row_end_m1;
  logic                         q_on;
  logic                         nonempty;
  logic [31:0]                  id_wide;

  always_comb begin
    left_s      = {{(COL_CALC_W-9){in_left_column[8]}}, in_left_column};
    width_s     = {{(COL_CALC_W-8){1'b0}}, in_rect_width};
    cols_ext    = {{(COL_CALC_W-8){1'b0}}, screen_cols_r};
    acols_s     = (cols_ext < MAX_COLS_S) ? cols_ext : MAX_COLS_S;
    col_end_raw = left_s + width_s;
    col_start   = left_s[COL_CALC_W-1] ? '0 : left_s;
    col_end     = (col_end_raw < acols_s) ? col_end_raw : acols_s;
    col_end_m1  = col_end - COL_CALC_W'(1);

    top_s       = {{(ROW_CALC_W-8){in_top_row[7]}}, in_top_row};
    height_s    = {{(ROW_CALC_W-7){1'b0}}, in_rect_height};
    rows_ext    = {{(ROW_CALC_W-7){1'b0}}, screen_rows_r};
    arows_s     = (rows_ext < MAX_ROWS_S) ? rows_ext : MAX_ROWS_S;
    row_end_raw = top_s + height_s;
    row_start   = top_s[ROW_CALC_W-1] ? '0 : top_s;
    row_end     = (row_end_raw < arows_s) ? row_end_raw : arows_s;
    row_end_m1  = row_end - ROW_CALC_W'(1);

    nonempty = (col_start < col_end) && (row_start < row_end);
    q_on = !left_s[COL_CALC_W-1] && !top_s[ROW_CALC_W-1] &&
           (left_s < acols_s) && (top_s < arows_s);
    id_wide = {16'b0, in_window_id};
  end

  // walker and item registers
  logic [CB-1:0]           col_r, col_first_r, col_last_r;
  logic [RB-1:0]           row_r, row_last_r;
  logic [ID_BITS-1:0]      pid_r;
  logic signed [LAYER_W-1:0] player_r;
  logic                    q_on_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r       <= col_start[CB-1:0];
      col_first_r <= col_start[CB-1:0];
      col_last_r  <= col_end_m1[CB-1:0];
      row_r       <= row_start[RB-1:0];
      row_last_r  <= row_end_m1[RB-1:0];
      pid_r       <= id_wide[ID_BITS-1:0];
      player_r    <= in_layer;
      q_on_r      <= q_on;
    end else if (cmd.paint_step) begin
      if (col_r == col_last_r) begin
        col_r <= col_first_r;
        row_r <= row_r + RB'(1);
      end else begin
        col_r <= col_r + CB'(1);
      end
    end
  end

  // read stage tag for the read-modify-write of a painted cell
  logic          p1_valid_r;
  logic [AW-1:0] p1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= cmd.paint_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.paint_step) begin
      p1_addr_r <= {row_r, col_r};
    end
  end

  // clearing sweep counter
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.load) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // status back to the controller
  assign sts = '{paint_nonempty: nonempty,
                 paint_last:     (col_r == col_last_r) && (row_r == row_last_r),
                 clr_last:       (clr_addr_r == LAST_ADDR)};

  // ownership memory: one write port, one registered read port
  logic [EW-1:0]             mem [DEPTH];
  logic [EW-1:0]             rd_data_r;
  logic [ID_BITS-1:0]        rd_id;
  logic signed [LAYER_W-1:0] rd_layer;
  logic                      claim;
  logic                      we;
  logic [AW-1:0]             wa;
  logic [EW-1:0]             wd;

  always_comb begin
    rd_id    = rd_data_r[EW-1:LAYER_W];
    rd_layer = rd_data_r[LAYER_W-1:0];
    claim    = (rd_id == '0) || (rd_layer < player_r);
    we       = cmd.clr_en || (p1_valid_r && claim);
    wa       = cmd.clr_en ? clr_addr_r : p1_addr_r;
    wd       = cmd.clr_en ? '0 : {pid_r, player_r};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[{row_r, col_r}];
    end
  end

  // result register
  logic [32:0] rd_id_wide;

  assign rd_id_wide = {{(33-ID_BITS){1'b0}}, rd_id};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_owner_id    <= q_on_r ? rd_id_wide[PORT_ID_W-1:0] : '0;
      out_owner_layer <= q_on_r ? rd_layer : '0;
      out_cell_valid  <= q_on_r;
    end
  end

endmodule

`default_nettype wire

>>> hdl/wlom_ctrl.sv
// controller: sequences clear sweeps, paint walks and queries
`default_nettype none

module wlom_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  wire  [1:0]      in_kind,
  output logic            out_valid,
  input  wire             out_stall,
  input  wlom_pkg::sts_t  sts,
  output wlom_pkg::cmd_t  cmd
);
  import wlom_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state and result valid registers; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_kind)
            KIND_CLEAR: state_nxt = ST_CLEAR;
            KIND_PAINT: begin
              if (sts.paint_nonempty) begin
                state_nxt = ST_PAINT;
              end
            end
            KIND_QUERY: state_nxt = ST_QREAD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PAINT: begin
        cmd.paint_step = 1'b1;
        cmd.rd_en      = 1'b1;
        if (sts.paint_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QREAD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_QOUT;
      end
      ST_QOUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // result valid: set on load, dropped once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> hdl/window_layer_ownership_map.sv
// Per-cell window ownership map of a character screen.
// Paint: walks the on-screen cells of the clipped rectangle, reading each through the
// registered read port and writing it back if claimed. Query: the cell is read in ST_QREAD
// and the result loaded in ST_QOUT; the next item is taken while a result waits.
// Clear: writes MAX_ROWS * 2**clog2(MAX_COLUMNS) empty entries (8192 at defaults), one entry a cycle.
// Reset (rst_n low, synchronous) starts the same clearing sweep; no item taken.
`default_nettype none

`include "window_layer_ownership_map_defines.svh"

module window_layer_ownership_map #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int ID_BITS     = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [1:0]                           in_kind,
  input  wire  [15:0]                          in_window_id,
  input  wire  signed [8:0]                    in_left_column,
  input  wire  signed [7:0]                    in_top_row,
  input  wire  [7:0]                           in_rect_width,
  input  wire  [6:0]                           in_rect_height,
  input  wire  signed [15:0]                   in_layer,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [15:0]                          out_owner_id,
  output logic signed [15:0]                   out_owner_layer,
  output logic                                 out_cell_valid,
  input  wire                                  cfg_we,
  input  wire  [wlom_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [wlom_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import wlom_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  wlom_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // map storage and walker
  wlom_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_window_id    (in_window_id),
    .in_left_column  (in_left_column),
    .in_top_row      (in_top_row),
    .in_rect_width   (in_rect_width),
    .in_rect_height  (in_rect_height),
    .in_layer        (in_layer),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_owner_id    (out_owner_id),
    .out_owner_layer (out_owner_layer),
    .out_cell_valid  (out_cell_valid)
  );

  // checks
  `WLOM_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, cmd.out_load, !out_valid || !out_stall, "result register loaded while a result is still waiting")
  `WLOM_ASSERT_NEXT(a_load_gives_valid, clk, rst_n, cmd.out_load, out_valid, "loaded result not shown as valid")
  `WLOM_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, cmd.clr_en, in_stall && !cmd.rd_en, "item taken or read issued during clearing sweep")

endmodule

`default_nettype wire

>>> verif/window_layer_ownership_map_tb.sv
// self-checking testbench for the window layer ownership map
`timescale 1ns / 1ps

module window_layer_ownership_map_tb;
  import wlom_pkg::*;

  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 8400;
  localparam int         HOLD_CYCLES   = 400;

  typedef struct {
    logic [15:0] id;
    logic [15:0] layer;
    logic        valid;
  } cell_report_t;

  // mirror of the ownership map plus the queue of query answers still owed
  class ownership_scoreboard;
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;

    int unsigned  owner_ids[CELLS];
    int           owner_layers[CELLS];
    int unsigned  screen_columns;
    int unsigned  screen_rows;
    cell_report_t pending_reports[$];
    int           failures;

    function new();
      screen_columns = SCREEN_COLUMNS_RESET;
      screen_rows    = SCREEN_ROWS_RESET;
      failures       = 0;
      wipe_map();
    endfunction

    function void wipe_map();
      for (int i = 0; i < CELLS; i++) begin
        owner_ids[i]    = 0;
        owner_layers[i] = 0;
      end
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_SCREEN_COLUMNS) begin
        screen_columns = value;
      end else if (idx == REG_SCREEN_ROWS) begin
        screen_rows = value[6:0];
      end
    endfunction

    // cell lies inside the usable area, clamped to the map size
    function bit on_screen(int col, int row);
      int cols;
      int rows;
      cols = (screen_columns < MAX_COLUMNS) ? screen_columns : MAX_COLUMNS;
      rows = (screen_rows < MAX_ROWS) ? screen_rows : MAX_ROWS;
      return col >= 0 && row >= 0 && col < cols && row < rows;
    endfunction

    // claim empty or strictly lower cells of the rectangle
    function void paint_rect(int unsigned id, int left, int top, int w, int h, int lay);
      int col;
      int row;
      int idx;
      for (int dy = 0; dy < h; dy++) begin
        for (int dx = 0; dx < w; dx++) begin
          col = left + dx;
          row = top + dy;
          if (on_screen(col, row)) begin
            idx = row * MAX_COLUMNS + col;
            if (owner_ids[idx] == 0 || owner_layers[idx] < lay) begin
              owner_ids[idx]    = id;
              owner_layers[idx] = lay;
            end
          end
        end
      end
    endfunction

    function void note_item(logic [1:0] kind, logic [15:0] id, logic signed [8:0] left,
                            logic signed [7:0] top, logic [7:0] w, logic [6:0] h,
                            logic signed [15:0] lay);
      cell_report_t rep;
      int col;
      int row;
      col = left;
      row = top;
      case (kind)
        KIND_CLEAR: begin
          wipe_map();
        end
        KIND_PAINT: begin
          paint_rect(id, col, row, w, h, lay);
        end
        KIND_QUERY: begin
          if (on_screen(col, row)) begin
            rep.id    = 16'(owner_ids[row * MAX_COLUMNS + col]);
            rep.layer = 16'(owner_layers[row * MAX_COLUMNS + col]);
            rep.valid = 1'b1;
          end else begin
            rep.id    = '0;
            rep.layer = '0;
            rep.valid = 1'b0;
          end
          pending_reports.insert(pending_reports.size(), rep);
        end
        default: begin
          // unused kind leaves the map alone
        end
      endcase
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic [15:0] id, logic [15:0] layer, logic valid);
      cell_report_t want;
      if (pending_reports.size() == 0) begin
        flag($sformatf("unexpected result: id %h layer %h valid %b", id, layer, valid));
        return;
      end
      want = pending_reports.pop_front();
      if (id !== want.id || layer !== want.layer || valid !== want.valid) begin
        flag($sformatf("expected id %h layer %h valid %b, got id %h layer %h valid %b",
                       want.id, want.layer, want.valid, id, layer, valid));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    in_kind;
  logic [15:0]                   in_window_id;
  logic signed [8:0]             in_left_column;
  logic signed [7:0]             in_top_row;
  logic [7:0]                    in_rect_width;
  logic [6:0]                    in_rect_height;
  logic signed [15:0]            in_layer;
  logic                          out_valid;
  logic                          out_stall;
  logic [15:0]                   out_owner_id;
  logic signed [15:0]            out_owner_layer;
  logic                          out_cell_valid;
  logic                          cfg_we;
  logic [CFG_INDEX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;

  ownership_scoreboard sb;
  int cur_cols = SCREEN_COLUMNS_RESET;
  int cur_rows = SCREEN_ROWS_RESET;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  window_layer_ownership_map dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_window_id   (in_window_id),
    .in_left_column (in_left_column),
    .in_top_row     (in_top_row),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_layer       (in_layer),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_owner_id   (out_owner_id),
    .out_owner_layer(out_owner_layer),
    .out_cell_valid (out_cell_valid),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #6 clk = ~clk;

  // offer one item, optionally after an idle burst, and wait for acceptance
  task automatic send_item(logic [1:0] kind, logic [15:0] id, int left, int top,
                           int w, int h, int lay);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_window_id   <= id;
    in_left_column <= left[8:0];
    in_top_row     <= top[7:0];
    in_rect_width  <= w[7:0];
    in_rect_height <= h[6:0];
    in_layer       <= lay[15:0];
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, id, left[8:0], top[7:0], w[7:0], h[6:0], lay[15:0]);
  endtask

  task automatic query_cell(int col, int row);
    send_item(KIND_QUERY, 16'($urandom), col, row, $urandom_range(0, 128),
              $urandom_range(0, 64), int'($urandom_range(0, 65535)));
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_reg(idx, value[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(int cols, int rows);
    write_reg(REG_SCREEN_COLUMNS, cols);
    write_reg(REG_SCREEN_ROWS, rows);
    cur_cols = cols;
    cur_rows = rows;
  endtask

  // stop offering, collect every owed answer, then let a clear or paint finish
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int          pick;
    int          shape;
    int          left;
    int          top;
    int          w;
    int          h;
    int          lay;
    logic [15:0] id;
    pick = $urandom_range(0, 99);
    id   = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
    // narrow layers make ties and overlaps common
    if ($urandom_range(0, 3) == 0) lay = int'($urandom_range(0, 65535)) - 32768;
    else lay = int'($urandom_range(0, 4)) - 2;
    if (pick < 4) begin
      send_item(KIND_CLEAR, id, 0, 0, 0, 0, lay);
    end else if (pick < 7) begin
      send_item(KIND_UNUSED, id, $urandom_range(0, 20), $urandom_range(0, 10),
                $urandom_range(1, 8), $urandom_range(1, 8), lay);
    end else if (pick < 54) begin
      shape = $urandom_range(0, 19);
      if (shape < 15) begin
        left = int'($urandom_range(0, cur_cols + 4)) - 4;
        top  = int'($urandom_range(0, cur_rows + 4)) - 4;
        w    = $urandom_range(0, 12);
        h    = $urandom_range(0, 6);
      end else if (shape < 18) begin
        left = int'($urandom_range(0, 40)) - 20;
        top  = int'($urandom_range(0, 20)) - 10;
        w    = $urandom_range(0, 128);
        h    = $urandom_range(0, 64);
      end else begin
        left = int'($urandom_range(0, 511)) - 256;
        top  = int'($urandom_range(0, 255)) - 128;
        w    = $urandom_range(0, 128);
        h    = $urandom_range(0, 64);
      end
      send_item(KIND_PAINT, id, left, top, w, h, lay);
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        query_cell($urandom_range(0, cur_cols), $urandom_range(0, cur_rows));
      end else begin
        query_cell(int'($urandom_range(0, 511)) - 256, int'($urandom_range(0, 255)) - 128);
      end
    end
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare every accepted result with the oldest owed answer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_owner_id, out_owner_layer, out_cell_valid);
    end
  end

  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_valid       <= 1'b0;
    in_kind        <= KIND_CLEAR;
    in_window_id   <= '0;
    in_left_column <= '0;
    in_top_row     <= '0;
    in_rect_width  <= '0;
    in_rect_height <= '0;
    in_layer       <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_SCREEN_COLUMNS;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed items on the reset screen size
    query_cell(0, 0);
    send_item(KIND_PAINT, 16'hFFFF, 0, 0, 4, 2, 32767);
    // equal layer, earlier window keeps the cells
    send_item(KIND_PAINT, 16'h0005, 0, 0, 4, 2, 32767);
    query_cell(3, 1);
    // id zero still counts as empty
    send_item(KIND_PAINT, 16'h0000, 10, 0, 2, 1, -32768);
    send_item(KIND_PAINT, 16'h0007, 10, 0, 1, 1, -32768);
    query_cell(10, 0);
    query_cell(11, 0);
    // empty rectangles
    send_item(KIND_PAINT, 16'h0009, 0, 0, 0, 5, 100);
    send_item(KIND_PAINT, 16'h0009, 0, 0, 5, 0, 100);
    // clipping on every edge
    send_item(KIND_PAINT, 16'h0003, -2, -1, 8, 3, -1);
    send_item(KIND_PAINT, 16'h1234, -256, -128, 128, 64, 5);
    send_item(KIND_PAINT, 16'hABCD, 78, 22, 128, 64, 1);
    query_cell(79, 23);
    query_cell(-1, 0);
    query_cell(0, -1);
    query_cell(80, 0);
    query_cell(0, 24);
    query_cell(255, 127);
    query_cell(-256, -128);
    send_item(KIND_UNUSED, 16'h5555, 4, 0, 4, 4, 32000);
    query_cell(4, 0);
    send_item(KIND_CLEAR, 16'h0000, 0, 0, 0, 0, 0);
    query_cell(0, 0);
    finish_phase();

    // largest screen
    set_screen(128, 64);
    repeat (20) random_item();
    finish_phase();

    // smallest screen, old contents stay out of reach
    set_screen(1, 1);
    repeat (12) random_item();
    finish_phase();

    // odd size with a long output hold while queries keep coming
    set_screen(37, 13);
    repeat (10) random_item();
    hold_req = 1'b1;
    while (hold_req) @(posedge clk);
    repeat (12) query_cell($urandom_range(0, cur_cols), $urandom_range(0, cur_rows));
    repeat (10) random_item();
    finish_phase();

    // back to back traffic with no idling
    set_screen(100, 50);
    quiet = 1'b1;
    repeat (20) random_item();
    finish_phase();

    if (sb.failures == 0 && sb.pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
